// ----- rtl/assert_macros.svh -----
// Shared concurrent assertion helpers, sampled on the rising clock edge
// and disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sicm_pkg.sv -----
package sicm_pkg;

    // Coefficient table depth (kernel taps per output pixel at most).
    localparam int MaxTaps  = 64;
    localparam int AddrW    = (MaxTaps > 1) ? $clog2(MaxTaps) : 1;
    localparam int LimW     = $clog2(MaxTaps + 1);

    localparam int CoefIdxW = 6;
    localparam int CoefW    = 16;
    localparam int PixW     = 8;
    localparam int AccW     = 16;
    localparam int ProdW    = PixW + 1 + CoefW;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;
    localparam int TapCntW  = 7;
    localparam int ShiftW   = 4;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TAP_COUNT   = 2'd0,
        CFG_TERM_SHIFT  = 2'd1,
        CFG_FINAL_SHIFT = 2'd2,
        CFG_OUT_OFFSET  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TAP  = 1'b1
    } t_req_type;

endpackage

// ----- rtl/sparse_int_convolution_mac.sv -----
// Channel   | Signals                                          | Direction
// ----------+--------------------------------------------------+----------
// input     | i_in_valid / o_in_ready, req_type, coef_*, pixel | in
// output    | o_out_valid / i_out_ready, out_pixel             | out
// config    | i_cfg_we, i_cfg_idx, i_cfg_data                  | in
//
// One request per cycle while o_in_ready is high; a pixel's result passes the table read,
// multiply, accumulate and clamp registers to o_out_valid after its last tap is accepted.
// Coefficient loads write the table on their accept cycle and do not enter the pipeline.
// Synchronous active-low reset clears control, counters, accumulator and config;
// the coefficient table keeps its contents and must be loaded before use.
// A held result backs up only the stages behind it; bubbles collapse.
`include "assert_macros.svh"

module sparse_int_convolution_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_req_type,
    input  logic [sicm_pkg::CoefIdxW-1:0]      i_coef_index,
    input  logic signed [sicm_pkg::CoefW-1:0]  i_coef_value,
    input  logic [sicm_pkg::PixW-1:0]          i_pixel,

    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [sicm_pkg::PixW-1:0]          o_out_pixel,

    input  logic                               i_cfg_we,
    input  logic [sicm_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [sicm_pkg::CfgDataW-1:0]      i_cfg_data
);
    import sicm_pkg::*;

    // Configuration
    logic [TapCntW-1:0]       r_tap_count;
    logic [ShiftW-1:0]        r_term_shift;
    logic [ShiftW-1:0]        r_final_shift;
    logic signed [AccW-1:0]   r_out_offset;

    // Coefficient table and tap state
    logic signed [CoefW-1:0]  coef_mem [MaxTaps];
    logic [AddrW-1:0]         r_tap_ctr;
    logic signed [AccW-1:0]   r_acc;

    // Stage 1: table read data
    logic                     r_s1_valid;
    logic                     r_s1_last;
    logic [PixW-1:0]          r_s1_pixel;
    logic signed [CoefW-1:0]  r_s1_coef;

    // Stage 2: product
    logic                     r_s2_valid;
    logic                     r_s2_last;
    logic signed [ProdW-1:0]  r_s2_prod;

    // Stage 3: finished sum
    logic                     r_s3_valid;
    logic signed [AccW-1:0]   r_s3_acc;

    // Output register
    logic                     r_o_valid;
    logic [PixW-1:0]          r_o_pixel;

    logic                     in_acc;
    logic                     load_acc;
    logic                     tap_acc;
    logic [LimW-1:0]          limit;
    logic                     tap_last;
    logic                     out_free;
    logic                     s3_go;
    logic                     s3_free;
    logic                     s2_go;
    logic                     s2_free;
    logic                     s1_go;
    logic                     s1_free;
    logic signed [ProdW-1:0]  n_s2_prod;
    logic signed [ProdW-1:0]  prod_shr;
    logic signed [AccW-1:0]   term;
    logic signed [AccW:0]     sum_wide;
    logic signed [AccW-1:0]   n_acc_sat;
    logic signed [AccW-1:0]   fin_shr;
    logic signed [AccW:0]     res_wide;
    logic [PixW-1:0]          n_o_pixel;

    // Stall chain: a stage moves when the stage ahead is empty or moving.
    assign out_free = !r_o_valid || i_out_ready;
    assign s3_go    = r_s3_valid && out_free;
    assign s3_free  = !r_s3_valid || s3_go;
    assign s2_go    = r_s2_valid && s3_free;
    assign s2_free  = !r_s2_valid || s2_go;
    assign s1_go    = r_s1_valid && s2_free;
    assign s1_free  = !r_s1_valid || s1_go;

    assign o_in_ready = s1_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign load_acc   = in_acc && (i_req_type == REQ_LOAD);
    assign tap_acc    = in_acc && (i_req_type == REQ_TAP);

    // Zero acts as one, anything past the table depth as the depth.
    always_comb begin
        if (r_tap_count == '0) begin
            limit = LimW'(1);
        end else if (32'(r_tap_count) > MaxTaps) begin
            limit = LimW'(MaxTaps);
        end else begin
            limit = LimW'(r_tap_count);
        end
    end

    assign tap_last = (32'(r_tap_ctr) + 32'd1) >= 32'(limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count   <= TapCntW'(1);
            r_term_shift  <= '0;
            r_final_shift <= '0;
            r_out_offset  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TAP_COUNT:   r_tap_count   <= i_cfg_data[TapCntW-1:0];
                CFG_TERM_SHIFT:  r_term_shift  <= i_cfg_data[ShiftW-1:0];
                CFG_FINAL_SHIFT: r_final_shift <= i_cfg_data[ShiftW-1:0];
                CFG_OUT_OFFSET:  r_out_offset  <= $signed(i_cfg_data[AccW-1:0]);
                default: ;
            endcase
        end
    end

    // Table port: a load writes, a tap reads the slot of its tap number.
    always_ff @(posedge i_clk) begin
        if (load_acc && (32'(i_coef_index) < MaxTaps)) begin
            coef_mem[AddrW'(i_coef_index)] <= i_coef_value;
        end
        if (tap_acc) begin
            r_s1_coef <= coef_mem[r_tap_ctr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_ctr <= '0;
        end else if (tap_acc) begin
            r_tap_ctr <= tap_last ? '0 : r_tap_ctr + AddrW'(1);
        end
    end

    // Stage 1 -> 2: multiply
    assign n_s2_prod = $signed({1'b0, r_s1_pixel}) * r_s1_coef;

    // Stage 2 -> 3: scale term, saturating accumulate
    assign prod_shr = r_s2_prod >>> r_term_shift;
    assign term     = prod_shr[AccW-1:0];
    assign sum_wide = {r_acc[AccW-1], r_acc} + {term[AccW-1], term};

    always_comb begin
        if (sum_wide[AccW] != sum_wide[AccW-1]) begin
            n_acc_sat = sum_wide[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
        end else begin
            n_acc_sat = sum_wide[AccW-1:0];
        end
    end

    // Stage 3 -> out: final shift, offset at full width, clamp to pixel range
    assign fin_shr  = r_s3_acc >>> r_final_shift;
    assign res_wide = {fin_shr[AccW-1], fin_shr} + {r_out_offset[AccW-1], r_out_offset};

    always_comb begin
        if (res_wide[AccW]) begin
            n_o_pixel = '0;
        end else if (res_wide > $signed((AccW+1)'(255))) begin
            n_o_pixel = '1;
        end else begin
            n_o_pixel = res_wide[PixW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_acc      <= '0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= tap_acc;
            end
            if (s2_free) begin
                r_s2_valid <= s1_go;
            end
            if (s3_free) begin
                r_s3_valid <= s2_go && r_s2_last;
            end
            if (out_free) begin
                r_o_valid <= s3_go;
            end
            if (s2_go) begin
                r_acc <= r_s2_last ? '0 : n_acc_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tap_acc) begin
            r_s1_pixel <= i_pixel;
            r_s1_last  <= tap_last;
        end
        if (s1_go) begin
            r_s2_prod <= n_s2_prod;
            r_s2_last <= r_s1_last;
        end
        if (s2_go && r_s2_last) begin
            r_s3_acc <= n_acc_sat;
        end
        if (s3_go) begin
            r_o_pixel <= n_o_pixel;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_pixel = r_o_pixel;

    `ASSERT_NEXT(a_last_tap_clears_ctr, i_clk, i_rst_n, tap_acc && tap_last, r_tap_ctr == '0, "tap counter not cleared after last tap")
    `ASSERT_NEXT(a_tap_advances_ctr, i_clk, i_rst_n, tap_acc && !tap_last, r_tap_ctr == $past(r_tap_ctr) + AddrW'(1), "tap counter did not advance")
    `ASSERT_NEXT(a_load_keeps_ctr, i_clk, i_rst_n, load_acc, $stable(r_tap_ctr), "load moved the tap counter")
    `ASSERT_SAME(a_s3_stall_cause, i_clk, i_rst_n, r_s3_valid && !s3_go, r_o_valid && !i_out_ready, "finished sum held without a blocked output")
    `ASSERT_SAME(a_in_stall_cause, i_clk, i_rst_n, !o_in_ready, r_s1_valid && r_s2_valid && r_s3_valid && r_o_valid, "input stalled with a free stage")

endmodule
